// File: design/tqe_pkg.sv
// ============================================================================
// tqe_pkg: shared types and constants for the timer queue engine
// Holds function codes, result kinds, status codes and the controller to
// datapath command and status structures.
// ============================================================================
package tqe_pkg;

    localparam int TIMER_SLOTS_DEFAULT = 16;

    localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    localparam logic [1:0] FUNC_ADD_ONCE   = 2'd0;
    localparam logic [1:0] FUNC_ADD_REPEAT = 2'd1;
    localparam logic [1:0] FUNC_ERASE      = 2'd2;
    localparam logic [1:0] FUNC_RUN        = 2'd3;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_ERASE = 2'd1;
    localparam logic [1:0] KIND_FIRE  = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [1:0] STAT_RUNAWAY  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the input transaction
        logic scan_clear;  // reset scan pointer and best candidate
        logic scan_step;   // examine the slot at the scan pointer
        logic do_add;      // write the chosen free slot
        logic do_erase;    // free the matched slot
        logic do_fire;     // fire the best candidate
    } tqe_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;   // the pointer has passed the last slot
        logic found;       // a candidate was found in the scan
    } tqe_sts_t;

    // Saturating add of a 32-bit unsigned delay to a signed 64-bit time.
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] t,
                                                   input logic [31:0] d);
        logic signed [64:0] s;
        begin
            s = {t[63], t} + {33'd0, d};
            sat_add = (s > $signed({1'b0, INT64_MAX})) ? INT64_MAX : s[63:0];
        end
    endfunction

endpackage

// File: design/tqe_ctrl.sv
// ============================================================================
// tqe_ctrl: sequencer for the timer queue engine
// Steps through scan passes and drives the result handshake.
// ============================================================================
module tqe_ctrl
    import tqe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_take,
    input  logic [1:0] func,
    input  logic       out_free,
    input  tqe_sts_t   sts,
    output tqe_cmd_t   cmd,
    output logic       busy,
    output logic       out_load,
    output logic [1:0] out_sel
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_ACT, ST_FIRE_SCAN, ST_FIRE, ST_FINAL, ST_WAIT
    } state_t;

    state_t     state_reg;
    logic [1:0] func_reg;

    // out_sel: 0 simple reply, 1 fire, 2 run finished.
    always_comb
    begin
        cmd = '0;
        out_load = 1'b0;
        out_sel = 2'd0;
        cmd.load = in_take;
        cmd.scan_clear = in_take;
        case (state_reg)
            ST_SCAN, ST_FIRE_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ST_ACT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    cmd.do_add = (func_reg == FUNC_ADD_ONCE) || (func_reg == FUNC_ADD_REPEAT);
                    cmd.do_erase = (func_reg == FUNC_ERASE);
                end
            end
            ST_FIRE:
            begin
                if (out_free)
                begin
                    if (sts.found)
                    begin
                        out_load = 1'b1;
                        out_sel = 2'd1;
                        cmd.do_fire = 1'b1;
                        cmd.scan_clear = 1'b1;
                    end
                    else
                    begin
                        cmd.scan_clear = 1'b1;
                    end
                end
            end
            ST_FINAL:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done && out_free)
                begin
                    out_load = 1'b1;
                    out_sel = 2'd2;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            func_reg <= FUNC_ADD_ONCE;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        func_reg <= func;
                        state_reg <= (func == FUNC_RUN) ? ST_FIRE_SCAN : ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (sts.scan_done)
                    begin
                        state_reg <= ST_ACT;
                    end
                end
                ST_ACT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_FIRE_SCAN:
                begin
                    if (sts.scan_done)
                    begin
                        state_reg <= ST_FIRE;
                    end
                end
                ST_FIRE:
                begin
                    if (out_free)
                    begin
                        state_reg <= sts.found ? ST_FIRE_SCAN : ST_FINAL;
                    end
                end
                ST_FINAL:
                begin
                    if (sts.scan_done && out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/tqe_datapath.sv
// ============================================================================
// tqe_datapath: timer table and slot scanner
// Holds the timer slots and examines one slot per cycle under command of
// the controller.
// ============================================================================
module tqe_datapath
    import tqe_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  tqe_cmd_t           cmd,
    input  logic [1:0]         func,
    input  logic signed [63:0] now,
    input  logic [31:0]        delay,
    input  logic [31:0]        timer_id,
    input  logic               single_pass,
    output tqe_sts_t           sts,
    output logic [1:0]         rep_status,
    output logic [31:0]        rep_id,
    output logic [31:0]        fire_id,
    output logic signed [63:0] next_time,
    output logic               runaway,
    output logic signed [63:0] now_q
);

    localparam int PW = $clog2(TIMER_SLOTS + 1);
    localparam int IW = $clog2(TIMER_SLOTS);

    logic [TIMER_SLOTS-1:0] valid_reg;
    logic [TIMER_SLOTS-1:0] fired_reg;
    logic [31:0]        id_reg       [TIMER_SLOTS];
    logic signed [63:0] expiry_reg   [TIMER_SLOTS];
    logic               repeat_reg   [TIMER_SLOTS];
    logic [31:0]        interval_reg [TIMER_SLOTS];
    logic [31:0]        order_reg    [TIMER_SLOTS];
    logic [31:0]        next_id_reg;
    logic [31:0]        insert_reg;

    logic [1:0]         func_reg;
    logic signed [63:0] now_reg;
    logic [31:0]        delay_reg;
    logic [31:0]        tid_reg;
    logic               once_reg;

    logic [PW-1:0]      ptr_reg;
    logic               found_reg;
    logic [IW-1:0]      best_reg;
    logic signed [63:0] best_exp_reg;
    logic [31:0]        best_ord_reg;
    logic signed [63:0] min_reg;
    logic               runaway_reg;

    logic [IW-1:0]      idx;
    logic               v;
    logic               better;
    logic               hit;
    logic               is_add;

    assign idx = ptr_reg[IW-1:0];
    assign v = valid_reg[idx];
    assign is_add = (func_reg == FUNC_ADD_ONCE) || (func_reg == FUNC_ADD_REPEAT);
    assign better = !found_reg || (expiry_reg[idx] < best_exp_reg)
                    || ((expiry_reg[idx] == best_exp_reg) && (order_reg[idx] < best_ord_reg));

    // A slot fires at most once per run, so a re-armed entry that is
    // already due again is left for the runaway check.
    always_comb
    begin
        hit = 1'b0;
        case (func_reg)
            FUNC_ADD_ONCE, FUNC_ADD_REPEAT: hit = !v;
            FUNC_ERASE: hit = v && (id_reg[idx] == tid_reg);
            FUNC_RUN: hit = v && !fired_reg[idx] && (expiry_reg[idx] <= now_reg) && better;
            default: hit = 1'b0;
        endcase
    end

    assign sts.scan_done = (ptr_reg == PW'(TIMER_SLOTS));
    assign sts.found = found_reg;

    always_comb
    begin
        if (is_add)
        begin
            rep_status = found_reg ? STAT_OK : STAT_FULL;
            rep_id = found_reg ? next_id_reg : 32'd0;
        end
        else
        begin
            rep_status = found_reg ? STAT_OK : STAT_NOTFOUND;
            rep_id = tid_reg;
        end
    end

    assign fire_id = id_reg[best_reg];
    assign next_time = min_reg;
    assign runaway = runaway_reg;
    assign now_q = now_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fired_reg <= '0;
            next_id_reg <= '0;
            insert_reg <= '0;
            ptr_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_clear)
            begin
                ptr_reg <= '0;
                found_reg <= 1'b0;
                min_reg <= INT64_MAX;
                runaway_reg <= 1'b0;
            end
            else if (cmd.scan_step && !sts.scan_done)
            begin
                ptr_reg <= ptr_reg + PW'(1);
                if (v)
                begin
                    if (expiry_reg[idx] < min_reg)
                    begin
                        min_reg <= expiry_reg[idx];
                    end
                    if (!once_reg && (expiry_reg[idx] <= now_reg))
                    begin
                        runaway_reg <= 1'b1;
                    end
                end
                // Add and erase keep the lowest matching slot.
                if (hit && (func_reg == FUNC_RUN || !found_reg))
                begin
                    found_reg <= 1'b1;
                    best_reg <= idx;
                    best_exp_reg <= expiry_reg[idx];
                    best_ord_reg <= order_reg[idx];
                end
            end
            if (cmd.load)
            begin
                func_reg <= func;
                now_reg <= now;
                delay_reg <= delay;
                tid_reg <= timer_id;
                once_reg <= single_pass;
                fired_reg <= '0;
            end
            if (cmd.do_add && found_reg)
            begin
                valid_reg[best_reg] <= 1'b1;
                id_reg[best_reg] <= next_id_reg;
                expiry_reg[best_reg] <= sat_add(now_reg, delay_reg);
                repeat_reg[best_reg] <= (func_reg == FUNC_ADD_REPEAT);
                interval_reg[best_reg] <= (func_reg == FUNC_ADD_REPEAT) ? delay_reg : 32'd0;
                order_reg[best_reg] <= insert_reg;
                next_id_reg <= next_id_reg + 32'd1;
                insert_reg <= insert_reg + 32'd1;
            end
            if (cmd.do_erase && found_reg)
            begin
                valid_reg[best_reg] <= 1'b0;
            end
            if (cmd.do_fire)
            begin
                fired_reg[best_reg] <= 1'b1;
                if (repeat_reg[best_reg])
                begin
                    expiry_reg[best_reg] <= sat_add(now_reg, interval_reg[best_reg]);
                    order_reg[best_reg] <= insert_reg;
                    insert_reg <= insert_reg + 32'd1;
                end
                else
                begin
                    valid_reg[best_reg] <= 1'b0;
                end
            end
        end
    end

endmodule

// File: design/timeout_queue_engine.sv
// ============================================================================
// timeout_queue_engine: timer queue with one-shot and repeating timers
// Top level joining the sequencer, the timer table and the result register.
// ============================================================================
// Each transaction scans the TIMER_SLOTS table one slot per cycle. A run
// repeats a full scan to pick the earliest expired entry before each firing,
// one more scan that finds nothing left to fire, and then a final scan for
// the next expiry. One transaction is in work at a time. Results sit in an
// output register; the engine waits on a stalled output when it has a new
// result to hand over, and also after the scan that finds nothing to fire.
module timeout_queue_engine
    import tqe_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic signed [63:0] now,
    input  logic [31:0]        delay,
    input  logic [31:0]        timer_id,
    input  logic               single_pass,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic [1:0]         status,
    output logic [31:0]        result_id,
    output logic signed [63:0] time_value,
    output logic               last
);

    tqe_cmd_t           cmd;
    tqe_sts_t           sts;
    logic               busy;
    logic               out_load;
    logic [1:0]         out_sel;
    logic               out_free;
    logic               in_take;
    logic [1:0]         rep_status;
    logic [31:0]        rep_id;
    logic [31:0]        fire_id;
    logic signed [63:0] next_time;
    logic               runaway;
    logic signed [63:0] now_q;
    logic [1:0]         func_q_reg;

    logic               out_valid_reg;
    logic [1:0]         kind_reg;
    logic [1:0]         status_reg;
    logic [31:0]        id_reg;
    logic signed [63:0] time_reg;
    logic               last_reg;

    assign in_stall = busy;
    assign in_take = in_valid && !busy;
    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;

    tqe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_take  (in_take),
        .func     (func),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy),
        .out_load (out_load),
        .out_sel  (out_sel)
    );

    tqe_datapath #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .func        (func),
        .now         (now),
        .delay       (delay),
        .timer_id    (timer_id),
        .single_pass (single_pass),
        .sts         (sts),
        .rep_status  (rep_status),
        .rep_id      (rep_id),
        .fire_id     (fire_id),
        .next_time   (next_time),
        .runaway     (runaway),
        .now_q       (now_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            func_q_reg <= FUNC_ADD_ONCE;
        end
        else
        begin
            if (in_take)
            begin
                func_q_reg <= func;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                case (out_sel)
                    2'd1:
                    begin
                        kind_reg <= KIND_FIRE;
                        status_reg <= STAT_OK;
                        id_reg <= fire_id;
                        time_reg <= now_q;
                        last_reg <= 1'b0;
                    end
                    2'd2:
                    begin
                        kind_reg <= KIND_DONE;
                        status_reg <= runaway ? STAT_RUNAWAY : STAT_OK;
                        id_reg <= 32'd0;
                        time_reg <= next_time;
                        last_reg <= 1'b1;
                    end
                    default:
                    begin
                        kind_reg <= (func_q_reg == FUNC_ERASE) ? KIND_ERASE : KIND_ADD;
                        status_reg <= rep_status;
                        id_reg <= rep_id;
                        time_reg <= '0;
                        last_reg <= 1'b1;
                    end
                endcase
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign kind = kind_reg;
    assign status = status_reg;
    assign result_id = id_reg;
    assign time_value = time_reg;
    assign last = last_reg;

`ifndef SYNTHESIS
    // A new input transaction is never taken while the engine is working.
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_take) else $error("input taken while busy");
    // A result is never overwritten while it is stalled.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !out_load) else $error("stalled result overwritten");
    // A run-finished result always closes the transaction.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_DONE) |-> last_reg) else $error("done without last");
`endif

endmodule
